[rtl/fvpd_pkg.sv]
package fvpd_pkg;

    localparam int COUNT_W = 29;
    localparam int VALUE_W = 28;

    localparam logic [7:0] LEAD1_MASK = 8'h80;
    localparam logic [7:0] LEAD2_MASK = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF0;
    localparam logic [7:0] LEAD2_CODE = 8'h80;
    localparam logic [7:0] LEAD3_CODE = 8'hC0;
    localparam logic [7:0] LEAD4_CODE = 8'hE0;
    localparam logic [7:0] BITS2_MASK = 8'h3F;
    localparam logic [7:0] BITS3_MASK = 8'h1F;
    localparam logic [7:0] BITS4_MASK = 8'h0F;

    localparam logic [VALUE_W-1:0] DUMMY_PULSE = 28'd300;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_word_t;

    typedef struct packed {
        logic [VALUE_W-1:0] pulse_value;
        logic               is_dummy;
        logic               last;
    } out_word_t;

    // Results of one decoded byte: zero, one or two words, in order.
    typedef struct packed {
        logic      first_valid;
        logic      second_valid;
        out_word_t first;
        out_word_t second;
    } push_grp_t;

endpackage

[rtl/fvpd_decode.sv]
module fvpd_decode
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [fvpd_pkg::COUNT_W-1:0]        cfg_wdata,
    input  logic                                fire,
    input  fvpd_pkg::in_word_t                  word,
    output fvpd_pkg::push_grp_t                 push
);

    logic [fvpd_pkg::COUNT_W-1:0] pulse_count_reg;
    logic [1:0]                   pending_reg;
    logic [1:0]                   pending_next;
    logic [fvpd_pkg::VALUE_W-1:0] accum_reg;
    logic [fvpd_pkg::VALUE_W-1:0] accum_next;
    logic [fvpd_pkg::COUNT_W-1:0] done_cnt_reg;
    logic [fvpd_pkg::COUNT_W-1:0] done_cnt_next;
    logic                         finished_reg;
    logic                         finished_next;

    logic                         skip;
    logic                         code_done;
    logic                         emit;
    logic                         close;
    logic [1:0]                   dec_pending;
    logic [fvpd_pkg::VALUE_W-1:0] dec_accum;
    logic [fvpd_pkg::COUNT_W-1:0] done_inc;
    logic [7:0]                   c;

    assign c = word.data_byte;
    assign skip = (pulse_count_reg == '0) || finished_reg;
    assign done_inc = done_cnt_reg + fvpd_pkg::COUNT_W'(1);

    // Lead-byte classification or continuation-byte accumulation.
    always_comb
    begin
        code_done   = 1'b0;
        emit        = 1'b0;
        dec_pending = pending_reg;
        dec_accum   = accum_reg;
        if (pending_reg != 2'd0)
        begin
            dec_accum   = {accum_reg[fvpd_pkg::VALUE_W-9:0], c};
            dec_pending = pending_reg - 2'd1;
            if (pending_reg == 2'd1)
            begin
                code_done = 1'b1;
                emit      = 1'b1;
            end
        end
        else if ((c & fvpd_pkg::LEAD1_MASK) == 8'h00)
        begin
            dec_accum = fvpd_pkg::VALUE_W'(c);
            code_done = 1'b1;
            emit      = 1'b1;
        end
        else if ((c & fvpd_pkg::LEAD2_MASK) == fvpd_pkg::LEAD2_CODE)
        begin
            dec_accum   = fvpd_pkg::VALUE_W'(c & fvpd_pkg::BITS2_MASK);
            dec_pending = 2'd1;
        end
        else if ((c & fvpd_pkg::LEAD3_MASK) == fvpd_pkg::LEAD3_CODE)
        begin
            dec_accum   = fvpd_pkg::VALUE_W'(c & fvpd_pkg::BITS3_MASK);
            dec_pending = 2'd2;
        end
        else if ((c & fvpd_pkg::LEAD4_MASK) == fvpd_pkg::LEAD4_CODE)
        begin
            dec_accum   = fvpd_pkg::VALUE_W'(c & fvpd_pkg::BITS4_MASK);
            dec_pending = 2'd3;
        end
        else
        begin
            // Reserved lead byte: counts as a code, produces no pulse word.
            code_done = 1'b1;
        end
    end

    assign close = !skip && ((code_done && (done_inc >= pulse_count_reg)) || word.last_byte);

    always_comb
    begin
        pending_next  = pending_reg;
        accum_next    = accum_reg;
        done_cnt_next = done_cnt_reg;
        finished_next = finished_reg;
        if (fire)
        begin
            if (!skip)
            begin
                pending_next = dec_pending;
                accum_next   = dec_accum;
                if (code_done)
                begin
                    done_cnt_next = done_inc;
                    accum_next    = '0;
                end
                if (close)
                begin
                    finished_next = 1'b1;
                    pending_next  = 2'd0;
                    accum_next    = '0;
                end
            end
            if (word.last_byte)
            begin
                pending_next  = 2'd0;
                accum_next    = '0;
                done_cnt_next = '0;
                finished_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        push = '0;
        if (fire && !skip)
        begin
            if (emit)
            begin
                push.first_valid       = 1'b1;
                push.first.pulse_value = dec_accum;
                if (close)
                begin
                    push.second_valid       = 1'b1;
                    push.second.pulse_value = fvpd_pkg::DUMMY_PULSE;
                    push.second.is_dummy    = 1'b1;
                    push.second.last        = 1'b1;
                end
            end
            else if (close)
            begin
                push.first_valid       = 1'b1;
                push.first.pulse_value = fvpd_pkg::DUMMY_PULSE;
                push.first.is_dummy    = 1'b1;
                push.first.last        = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_count_reg <= '0;
            pending_reg     <= 2'd0;
            accum_reg       <= '0;
            done_cnt_reg    <= '0;
            finished_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                pulse_count_reg <= cfg_wdata;
            end
            pending_reg  <= pending_next;
            accum_reg    <= accum_next;
            done_cnt_reg <= done_cnt_next;
            finished_reg <= finished_next;
        end
    end

    a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
        push.second_valid |-> push.first_valid && push.second.is_dummy)
        else $error("second word without a first word or not a dummy");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && word.last_byte) |=> (done_cnt_reg == '0) && !finished_reg
            && (pending_reg == 2'd0))
        else $error("packet state not cleared after last byte");

    a_skip_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && skip) |-> !push.first_valid)
        else $error("word produced while output is disabled or packet finished");

endmodule

[rtl/fvpd_outq.sv]
module fvpd_outq
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  fvpd_pkg::push_grp_t  push,
    output logic                 room,
    output logic                 dn_valid,
    input  logic                 dn_stall,
    output fvpd_pkg::out_word_t  dn_data
);

    fvpd_pkg::out_word_t              mem_reg [fvpd_pkg::QUEUE_DEPTH];
    logic [fvpd_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [fvpd_pkg::QPTR_W-1:0]      wr_ptr_next;
    logic [fvpd_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [fvpd_pkg::QPTR_W-1:0]      rd_ptr_next;
    logic [fvpd_pkg::QCNT_W-1:0]      count_reg;
    logic [fvpd_pkg::QCNT_W-1:0]      count_next;
    logic [fvpd_pkg::QPTR_W-1:0]      wr_ptr_plus1;
    logic [fvpd_pkg::QCNT_W-1:0]      push_num;
    logic                             pop;

    // Two free entries are always kept for a byte that yields two words.
    assign room = (count_reg <= fvpd_pkg::QCNT_W'(fvpd_pkg::QUEUE_DEPTH - 2));
    assign dn_valid = (count_reg != '0);
    assign dn_data  = mem_reg[rd_ptr_reg];
    assign pop      = dn_valid && !dn_stall;

    assign wr_ptr_plus1 = wr_ptr_reg + fvpd_pkg::QPTR_W'(1);
    assign push_num = fvpd_pkg::QCNT_W'(push.first_valid)
                    + fvpd_pkg::QCNT_W'(push.second_valid);
    assign wr_ptr_next = wr_ptr_reg + fvpd_pkg::QPTR_W'(push_num);
    assign rd_ptr_next = rd_ptr_reg + fvpd_pkg::QPTR_W'(pop);
    assign count_next  = count_reg + push_num - fvpd_pkg::QCNT_W'(pop);

    always_ff @(posedge clk)
    begin
        if (push.first_valid)
        begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (push.second_valid)
        begin
            mem_reg[wr_ptr_plus1] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push.first_valid |-> (count_reg <= fvpd_pkg::QCNT_W'(fvpd_pkg::QUEUE_DEPTH - 2)))
        else $error("push into queue without two free entries");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= fvpd_pkg::QCNT_W'(fvpd_pkg::QUEUE_DEPTH))
        else $error("queue count out of range");

    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_ptr_reg - rd_ptr_reg) == count_reg[fvpd_pkg::QPTR_W-1:0])
        else $error("queue pointers disagree with count");

endmodule

[rtl/flux_varint_pulse_decoder_top.sv]
// Flux pulse varint decoder.
//
// Upstream channel (up_valid / up_stall / up_data) carries one byte of an
// unpacked flux-stream packet per word, with last_byte marking the packet's
// final byte. Downstream channel (dn_valid / dn_stall / dn_data) carries the
// decoded pulse lengths; each packet that produces output closes with a dummy
// pulse of 300 flagged by is_dummy and last. The pulse_count register must be
// written via cfg_we / cfg_wdata only while the block is idle (unenforced).
//
// An accepted byte is held in an input register, decoded there, and its
// results are written into a four-entry output queue. A second result (the
// dummy after a final pulse) is written together with the first and follows
// it on dn_valid / dn_data. A zero pulse_count mutes the block.
// One byte is accepted every cycle as long as the queue has two free
// entries, so throughput is one byte per cycle and one result per cycle;
// the downstream port limits the rate when bytes yield two results.
// When the receiver stalls, the queue fills and up_stall rises once it holds
// more than two words while a byte is held. Reset clears the register, the
// packet state and the queue; the first byte after reset starts a new packet.
module flux_varint_pulse_decoder_top
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [fvpd_pkg::COUNT_W-1:0]  cfg_wdata,
    input  logic                          up_valid,
    output logic                          up_stall,
    input  fvpd_pkg::in_word_t            up_data,
    output logic                          dn_valid,
    input  logic                          dn_stall,
    output fvpd_pkg::out_word_t           dn_data
);

    fvpd_pkg::in_word_t  in_word_reg;
    logic                in_valid_reg;
    logic                in_valid_next;
    logic                room;
    logic                fire;
    fvpd_pkg::push_grp_t push;

    // The held byte is decoded once the queue can take two words.
    assign fire     = in_valid_reg && room;
    assign up_stall = in_valid_reg && !room;
    assign in_valid_next = up_stall ? in_valid_reg : up_valid;

    always_ff @(posedge clk)
    begin
        if (up_valid && !up_stall)
        begin
            in_word_reg <= up_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    fvpd_decode u_decode
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .fire      (fire),
        .word      (in_word_reg),
        .push      (push)
    );

    fvpd_outq u_outq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .room     (room),
        .dn_valid (dn_valid),
        .dn_stall (dn_stall),
        .dn_data  (dn_data)
    );

    a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        up_stall |=> in_valid_reg && $stable(in_word_reg))
        else $error("held byte lost while input stalled");

    a_fire_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !(up_valid && !up_stall)) |=> !in_valid_reg)
        else $error("input register still valid after decode with no new byte");

    a_push_needs_fire: assert property (@(posedge clk) disable iff (!rst_n)
        push.first_valid |-> fire)
        else $error("queue write without a decoded byte");

endmodule
